### src/dpec_pkg.sv
`timescale 1ns / 1ps

package dpec_pkg;

    // Field widths of the request and result items.
    localparam int VEL_W    = 16;
    localparam int MASS_W   = 16;
    localparam int RAD_W    = 15;
    localparam int IN_W     = 192;
    localparam int OUT_W    = 80;

    // Internal widths of the datapath.
    localparam int DIFF_W   = 17;
    localparam int SQD_W    = 33;
    localparam int D2_W     = 34;
    localparam int PRD_W    = 34;
    localparam int P_W      = 35;
    localparam int HALF_W   = 17;
    localparam int MSUM_W   = 17;
    localparam int NK_W     = 33;
    localparam int PART_W   = 50;
    localparam int NUM_W    = 67;
    localparam int DEN_W    = 52;
    localparam int Q_W      = 20;
    localparam int F_W      = 70;
    localparam int SQ_W     = 80;
    localparam int EXT_W    = 22;

    // Velocity deltas are computed in four lanes.
    localparam int LANES    = 4;
    localparam int LANE_1X  = 0;
    localparam int LANE_1Y  = 1;
    localparam int LANE_2X  = 2;
    localparam int LANE_2Y  = 3;

    // Latency of the divider and root pipelines.
    localparam int PIPE_LAT = Q_W + 1;

    localparam logic signed [EXT_W-1:0] VMAX = EXT_W'(32767);
    localparam logic signed [EXT_W-1:0] VMIN = -EXT_W'(32768);

    // Clamp a widened velocity into the 16-bit signed range.
    function automatic logic [VEL_W-1:0] sat16(input logic signed [EXT_W-1:0] v);
        logic [VEL_W-1:0] r;
        if (v > VMAX)
        begin
            r = 16'h7FFF;
        end
        else if (v < VMIN)
        begin
            r = 16'h8000;
        end
        else
        begin
            r = v[VEL_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/disc_pair_elastic_collision_unit.sv
`timescale 1ns / 1ps

// Elastic collision response for one pair of discs per request. The unit
// accepts a new pair in every cycle unless the result side stalls, and
// returns one result per pair, in order: five stages form the differences,
// squares, products and the divisor, then four 20-stage restoring dividers
// (one per velocity component) and a 20-stage bit-serial root search for the
// approach speed run side by side, each divider followed by a rounding
// register and the root by a saturating register, and one output register
// applies the deltas and saturates. The whole pipeline advances together
// whenever the output register is empty or being taken, so a stall on the
// result side holds every stage in place and nothing is lost or repeated.
module disc_pair_elastic_collision_unit
    import dpec_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
    // first_radius, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
    // second_mass, second_radius, then two zero bits
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y,
    // approach_speed
    output logic [OUT_W-1:0] m_tdata,
    // hit
    output logic             m_tuser
);

    typedef struct packed {
        logic signed [VEL_W-1:0] v1x;
        logic signed [VEL_W-1:0] v1y;
        logic signed [VEL_W-1:0] v2x;
        logic signed [VEL_W-1:0] v2y;
    } vel_t;

    typedef struct packed {
        vel_t vel;
        logic hit;
        logic sx;
        logic sy;
    } side_t;

    logic en;

    // Request fields.
    logic signed [VEL_W-1:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
    logic [MASS_W-1:0]       m1, m2;
    logic [RAD_W-1:0]        r1, r2;

    // Stage 1: differences.
    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] s1_dx_reg, s1_dy_reg, s1_dvx_reg, s1_dvy_reg;
    logic [VEL_W-1:0]         s1_rs_reg;
    logic [MASS_W-1:0]        s1_m1_reg, s1_m2_reg;
    vel_t                     s1_vel_reg;

    // Stage 2: squares and dot products per axis.
    logic                    s2_valid_reg;
    logic [SQD_W-1:0]        s2_dx2_reg, s2_dy2_reg;
    logic signed [PRD_W-1:0] s2_px_reg, s2_py_reg;
    logic [2*VEL_W-1:0]      s2_rs2_reg;
    logic [DIFF_W-1:0]       s2_adx_reg, s2_ady_reg;
    logic                    s2_sx_reg, s2_sy_reg;
    logic [MASS_W-1:0]       s2_m1_reg, s2_m2_reg;
    vel_t                    s2_vel_reg;
    logic signed [PRD_W-1:0] px_next, py_next;
    logic signed [SQD_W-1:0] dx2_next, dy2_next;

    // Stage 3: D2, P, mass sum and mass-distance products.
    logic                  s3_valid_reg;
    logic [D2_W-1:0]       s3_d2_reg;
    logic signed [P_W-1:0] s3_p_reg;
    logic [MSUM_W-1:0]     s3_msum_reg;
    logic [NK_W-1:0]       s3_nk_reg [LANES];
    logic [2*VEL_W-1:0]    s3_rs2_reg;
    logic                  s3_sx_reg, s3_sy_reg;
    vel_t                  s3_vel_reg;

    // Stage 4: hit test and partial products.
    logic               s4_valid_reg;
    logic               s4_hit_reg;
    logic [D2_W-1:0]    s4_d2_reg;
    logic [PRD_W-1:0]   s4_denl_reg, s4_denh_reg;
    logic [PART_W-1:0]  s4_pl_reg [LANES];
    logic [PART_W-1:0]  s4_ph_reg [LANES];
    logic [PRD_W-1:0]   s4_ll_reg, s4_lh_reg, s4_hh_reg;
    logic               s4_sx_reg, s4_sy_reg;
    vel_t               s4_vel_reg;
    logic               hit_next;
    logic [D2_W-1:0]    up;

    // Stage 5: divisor, numerators and 4*P^2.
    logic               s5_valid_reg;
    side_t              s5_side_reg;
    logic [D2_W-1:0]    s5_d2_reg;
    logic [DEN_W-1:0]   s5_den_reg;
    logic [NUM_W-1:0]   s5_num_reg [LANES];
    logic [F_W-1:0]     s5_f_reg;

    // Side information that travels beside the divider and root pipes.
    logic  side_valid_reg [PIPE_LAT];
    side_t side_reg       [PIPE_LAT];

    logic [Q_W-1:0]   quo [LANES];
    logic [VEL_W-1:0] speed;

    // Output register.
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_hit_reg;

    // Unpack the request.
    assign p1x = s_tdata[15:0];
    assign p1y = s_tdata[31:16];
    assign v1x = s_tdata[47:32];
    assign v1y = s_tdata[63:48];
    assign m1  = s_tdata[79:64];
    assign r1  = s_tdata[94:80];
    assign p2x = s_tdata[110:95];
    assign p2y = s_tdata[126:111];
    assign v2x = s_tdata[142:127];
    assign v2y = s_tdata[158:143];
    assign m2  = s_tdata[174:159];
    assign r2  = s_tdata[189:175];

    // The whole pipeline moves when the output register can take a result.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage 1: differences; two massless discs count as equal masses.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg  <= DIFF_W'(p2x) - DIFF_W'(p1x);
            s1_dy_reg  <= DIFF_W'(p2y) - DIFF_W'(p1y);
            s1_dvx_reg <= DIFF_W'(v1x) - DIFF_W'(v2x);
            s1_dvy_reg <= DIFF_W'(v1y) - DIFF_W'(v2y);
            s1_rs_reg  <= VEL_W'(r1) + VEL_W'(r2);
            if (m1 == '0 && m2 == '0)
            begin
                s1_m1_reg <= MASS_W'(1);
                s1_m2_reg <= MASS_W'(1);
            end
            else
            begin
                s1_m1_reg <= m1;
                s1_m2_reg <= m2;
            end
            s1_vel_reg <= '{v1x: v1x, v1y: v1y, v2x: v2x, v2y: v2y};
        end
    end

    // Stage 2: squares, per-axis dot products and magnitudes.
    assign px_next  = s1_dvx_reg * s1_dx_reg;
    assign py_next  = s1_dvy_reg * s1_dy_reg;
    assign dx2_next = s1_dx_reg * s1_dx_reg;
    assign dy2_next = s1_dy_reg * s1_dy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_dx2_reg <= $unsigned(dx2_next);
            s2_dy2_reg <= $unsigned(dy2_next);
            s2_px_reg  <= px_next;
            s2_py_reg  <= py_next;
            s2_rs2_reg <= s1_rs_reg * s1_rs_reg;
            s2_adx_reg <= s1_dx_reg[DIFF_W-1] ? DIFF_W'(-s1_dx_reg) : DIFF_W'(s1_dx_reg);
            s2_ady_reg <= s1_dy_reg[DIFF_W-1] ? DIFF_W'(-s1_dy_reg) : DIFF_W'(s1_dy_reg);
            s2_sx_reg  <= s1_dx_reg[DIFF_W-1];
            s2_sy_reg  <= s1_dy_reg[DIFF_W-1];
            s2_m1_reg  <= s1_m1_reg;
            s2_m2_reg  <= s1_m2_reg;
            s2_vel_reg <= s1_vel_reg;
        end
    end

    // Stage 3: D2, P and the mass-distance products of each lane.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_d2_reg            <= D2_W'(s2_dx2_reg) + D2_W'(s2_dy2_reg);
            s3_p_reg             <= P_W'(s2_px_reg) + P_W'(s2_py_reg);
            s3_msum_reg          <= MSUM_W'(s2_m1_reg) + MSUM_W'(s2_m2_reg);
            s3_nk_reg[LANE_1X]   <= s2_m2_reg * s2_adx_reg;
            s3_nk_reg[LANE_1Y]   <= s2_m2_reg * s2_ady_reg;
            s3_nk_reg[LANE_2X]   <= s2_m1_reg * s2_adx_reg;
            s3_nk_reg[LANE_2Y]   <= s2_m1_reg * s2_ady_reg;
            s3_rs2_reg           <= s2_rs2_reg;
            s3_sx_reg            <= s2_sx_reg;
            s3_sy_reg            <= s2_sy_reg;
            s3_vel_reg           <= s2_vel_reg;
        end
    end

    // Stage 4: overlap and approach test, split products.
    assign up       = s3_p_reg[D2_W-1:0];
    assign hit_next = (s3_d2_reg != '0) && (s3_d2_reg <= D2_W'(s3_rs2_reg))
                   && !s3_p_reg[P_W-1] && (s3_p_reg != '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_hit_reg  <= hit_next;
            s4_d2_reg   <= s3_d2_reg;
            s4_denl_reg <= s3_msum_reg * s3_d2_reg[HALF_W-1:0];
            s4_denh_reg <= s3_msum_reg * s3_d2_reg[D2_W-1:HALF_W];
            for (int k = 0; k < LANES; k++)
            begin
                s4_pl_reg[k] <= s3_nk_reg[k] * up[HALF_W-1:0];
                s4_ph_reg[k] <= s3_nk_reg[k] * up[D2_W-1:HALF_W];
            end
            s4_ll_reg  <= up[HALF_W-1:0] * up[HALF_W-1:0];
            s4_lh_reg  <= up[HALF_W-1:0] * up[D2_W-1:HALF_W];
            s4_hh_reg  <= up[D2_W-1:HALF_W] * up[D2_W-1:HALF_W];
            s4_sx_reg  <= s3_sx_reg;
            s4_sy_reg  <= s3_sy_reg;
            s4_vel_reg <= s3_vel_reg;
        end
    end

    // Stage 5: assemble divisor, doubled numerators and 4*P^2.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_den_reg <= DEN_W'(s4_denh_reg) * DEN_W'(2 ** HALF_W) + DEN_W'(s4_denl_reg);
            for (int k = 0; k < LANES; k++)
            begin
                s5_num_reg[k] <= ((NUM_W'(s4_ph_reg[k]) << HALF_W) + NUM_W'(s4_pl_reg[k])) << 1;
            end
            s5_f_reg    <= ((F_W'(s4_hh_reg) << (2 * HALF_W)) + (F_W'(s4_lh_reg) << (HALF_W + 1))
                          + F_W'(s4_ll_reg)) << 2;
            s5_d2_reg   <= s4_d2_reg;
            s5_side_reg <= '{vel: s4_vel_reg, hit: s4_hit_reg, sx: s4_sx_reg, sy: s4_sy_reg};
        end
    end

    // Quotient lanes and the approach speed root.
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        dpec_div_pipe u_div (
            .clk (clk),
            .en  (en),
            .num (s5_num_reg[k]),
            .den (s5_den_reg),
            .quo (quo[k])
        );
    end

    dpec_sqrt_pipe u_sqrt (
        .clk     (clk),
        .en      (en),
        .d2      (s5_d2_reg),
        .four_p2 (s5_f_reg),
        .speed   (speed)
    );

    // Delay line for valid bits and pass-through values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
            begin
                side_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            side_valid_reg[0] <= s5_valid_reg;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                side_valid_reg[i] <= side_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= s5_side_reg;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Apply the signed deltas and saturate.
    side_t                   fin;
    logic signed [EXT_W-1:0] q1x, q1y, q2x, q2y;
    logic signed [EXT_W-1:0] e1x, e1y, e2x, e2y;
    logic [VEL_W-1:0]        n1x, n1y, n2x, n2y, nspeed;

    assign fin = side_reg[PIPE_LAT-1];
    assign q1x = $signed(EXT_W'(quo[LANE_1X]));
    assign q1y = $signed(EXT_W'(quo[LANE_1Y]));
    assign q2x = $signed(EXT_W'(quo[LANE_2X]));
    assign q2y = $signed(EXT_W'(quo[LANE_2Y]));
    assign e1x = EXT_W'(fin.vel.v1x);
    assign e1y = EXT_W'(fin.vel.v1y);
    assign e2x = EXT_W'(fin.vel.v2x);
    assign e2y = EXT_W'(fin.vel.v2y);

    always_comb
    begin
        if (fin.hit)
        begin
            n1x    = sat16(fin.sx ? e1x + q1x : e1x - q1x);
            n1y    = sat16(fin.sy ? e1y + q1y : e1y - q1y);
            n2x    = sat16(fin.sx ? e2x - q2x : e2x + q2x);
            n2y    = sat16(fin.sy ? e2y - q2y : e2y + q2y);
            nspeed = speed;
        end
        else
        begin
            n1x    = fin.vel.v1x;
            n1y    = fin.vel.v1y;
            n2x    = fin.vel.v2x;
            n2y    = fin.vel.v2y;
            nspeed = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= side_valid_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {nspeed, n2y, n2x, n1y, n1x};
            out_hit_reg  <= fin.hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

endmodule

### src/dpec_div_pipe.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, rounded half away from zero.
module dpec_div_pipe
    import dpec_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];
    logic [Q_W-1:0]   low_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   round_reg;

    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [Q_W-1:0]   quo_in;
        logic [Q_W-1:0]   low_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic             ge;

        // Pick up the partial remainder from the stage before.
        if (i == 0)
        begin : g_first
            assign rem_in = DEN_W'(num >> Q_W);
            assign quo_in = '0;
            assign low_in = num[Q_W-1:0];
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign low_in = low_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        // Shift in one numerator bit and subtract when it fits.
        assign trial = {rem_in, low_in[Q_W-1]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
                quo_reg[i] <= {quo_in[Q_W-2:0], ge};
                low_reg[i] <= low_in << 1;
                den_reg[i] <= den_in;
            end
        end
    end

    // Round up when the remainder is at least half the divisor.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            round_reg <= quo_reg[Q_W-1] +
                Q_W'({rem_reg[Q_W-1], 1'b0} >= {1'b0, den_reg[Q_W-1]});
        end
    end

    assign quo = round_reg;

endmodule

### src/dpec_sqrt_pipe.sv
`timescale 1ns / 1ps

// Finds the largest a with (2a-1)^2 * D2 <= F, one bit per stage, using
// running values of a*a*D2 and a*D2 so that no stage multiplies.
module dpec_sqrt_pipe
    import dpec_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [D2_W-1:0]  d2,
    input  logic [F_W-1:0]   four_p2,
    output logic [VEL_W-1:0] speed
);

    logic [Q_W-1:0]   lo_reg [Q_W];
    logic [SQ_W-1:0]  x_reg  [Q_W];
    logic [SQ_W-1:0]  y_reg  [Q_W];
    logic [D2_W-1:0]  d_reg  [Q_W];
    logic [F_W-1:0]   f_reg  [Q_W];
    logic [VEL_W-1:0] speed_reg;

    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        localparam int B = Q_W - 1 - i;
        logic [Q_W-1:0]  lo_in;
        logic [SQ_W-1:0] x_in;
        logic [SQ_W-1:0] y_in;
        logic [D2_W-1:0] d_in;
        logic [F_W-1:0]  f_in;
        logic [SQ_W-1:0] dw;
        logic [SQ_W-1:0] val;
        logic            take;

        if (i == 0)
        begin : g_first
            assign lo_in = '0;
            assign x_in  = '0;
            assign y_in  = '0;
            assign d_in  = d2;
            assign f_in  = four_p2;
        end
        else
        begin : g_next
            assign lo_in = lo_reg[i-1];
            assign x_in  = x_reg[i-1];
            assign y_in  = y_reg[i-1];
            assign d_in  = d_reg[i-1];
            assign f_in  = f_reg[i-1];
        end

        // (2c-1)^2 * D2 for the candidate c = lo + 2^B.
        assign dw   = SQ_W'(d_in);
        assign val  = (x_in << 2) + (dw << (2 * B + 2)) + (y_in << (B + 3)) + dw
                    - (y_in << 2) - (dw << (B + 2));
        assign take = val <= SQ_W'(f_in);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo_reg[i] <= take ? (lo_in | (Q_W'(1) << B)) : lo_in;
                x_reg[i]  <= take ? (x_in + (y_in << (B + 1)) + (dw << (2 * B))) : x_in;
                y_reg[i]  <= take ? (y_in + (dw << B)) : y_in;
                d_reg[i]  <= d_in;
                f_reg[i]  <= f_in;
            end
        end
    end

    // Saturate the root to the 16-bit result field.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            speed_reg <= (lo_reg[Q_W-1] > Q_W'(16'hFFFF)) ? 16'hFFFF
                                                           : lo_reg[Q_W-1][VEL_W-1:0];
        end
    end

    assign speed = speed_reg;

endmodule

### src/dpec_checker.sv
`timescale 1ns / 1ps

// Port-level checks of the collision unit.
module dpec_checker
    import dpec_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // With the output register empty the unit always takes a request.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("request refused with empty output");

    // A miss reports no approach speed.
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[79:64] == '0)
        else $error("approach speed on a miss");

    // A stalled output cannot let a request in.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while output stalled");

endmodule

bind disc_pair_elastic_collision_unit dpec_checker u_dpec_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dpec_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;

    typedef struct packed {
        logic [15:0] v1x;
        logic [15:0] v1y;
        logic [15:0] v2x;
        logic [15:0] v2y;
        logic        hit;
        logic [15:0] speed;
    } response_t;

    // Request fields are kept unpacked here: index order matches tdata order.
    typedef logic [15:0] pair_t [12];

    disc_pair_elastic_collision_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    response_t expected_responses [$];
    int        mismatch_count;
    int        response_count;
    int        hit_count;
    bit        stimulus_done;

    // Directed stimulus table.
    pair_t     table_rows [$];
    bit        table_fixed [$];
    response_t table_resp [$];

    // Clock generator.
    initial
    begin
        clk = 1'b0;
    end
    always #4 clk = ~clk;

    // Appends one row to the directed table.
    function automatic void add_row(pair_t row, bit fixed, response_t resp);
        table_rows.insert(table_rows.size(), row);
        table_fixed.insert(table_fixed.size(), fixed);
        table_resp.insert(table_resp.size(), resp);
    endfunction

    function automatic logic [IN_W-1:0] pack_pair(pair_t f);
        logic [IN_W-1:0] d;
        int              pos;
        d   = '0;
        pos = 0;
        for (int i = 0; i < 12; i++)
        begin
            if (i == 5 || i == 11)
            begin
                d[pos +: 15] = f[i][14:0];
                pos += 15;
            end
            else
            begin
                d[pos +: 16] = f[i];
                pos += 16;
            end
        end
        return d;
    endfunction

    function automatic logic [15:0] clamp_vel(longint v);
        if (v > 32767)
        begin
            return 16'h7FFF;
        end
        if (v < -32768)
        begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // Rounded share of the normal exchange for one axis: halves away from zero.
    function automatic longint axis_delta(longint m, longint p, longint da,
                                          logic [127:0] den);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        longint       mag;
        mag = da < 0 ? -da : da;
        num = 128'(2 * m) * 128'(p) * 128'(mag);
        q   = num / den;
        r   = num % den;
        if (2 * r >= den)
        begin
            q = q + 1;
        end
        return da < 0 ? -longint'(q) : longint'(q);
    endfunction

    // Predicts the response to one disc pair.
    function automatic response_t collide(pair_t f);
        response_t    res;
        longint       p1x, p1y, v1x, v1y, m1, r1, p2x, p2y, v2x, v2y, m2, r2;
        longint       dx, dy, d2, rs, p;
        logic [127:0] den, p4, t;
        longint       root, cand, d1x, d1y, d2x, d2y;
        p1x = longint'($signed(f[0]));
        p1y = longint'($signed(f[1]));
        v1x = longint'($signed(f[2]));
        v1y = longint'($signed(f[3]));
        m1  = f[4];
        r1  = f[5][14:0];
        p2x = longint'($signed(f[6]));
        p2y = longint'($signed(f[7]));
        v2x = longint'($signed(f[8]));
        v2y = longint'($signed(f[9]));
        m2  = f[10];
        r2  = f[11][14:0];
        dx  = p2x - p1x;
        dy  = p2y - p1y;
        d2  = dx * dx + dy * dy;
        rs  = r1 + r2;
        p   = (v1x - v2x) * dx + (v1y - v2y) * dy;
        res = '0;
        if (d2 > 0 && d2 <= rs * rs && p > 0)
        begin
            res.hit = 1'b1;
            if (m1 + m2 == 0)
            begin
                m1 = 1;
                m2 = 1;
            end
            den = 128'(m1 + m2) * 128'(d2);
            d1x = axis_delta(m2, p, dx, den);
            d1y = axis_delta(m2, p, dy, den);
            d2x = axis_delta(m1, p, dx, den);
            d2y = axis_delta(m1, p, dy, den);
            v1x -= d1x;
            v1y -= d1y;
            v2x += d2x;
            v2y += d2y;
            // Largest a with (2a-1)^2 * D2 <= 4 P^2, found bit by bit.
            p4   = 128'(2 * p) * 128'(2 * p);
            root = 0;
            for (int b = 19; b >= 0; b--)
            begin
                cand = root | (longint'(1) << b);
                t    = 128'(2 * cand - 1) * 128'(2 * cand - 1) * 128'(d2);
                if (t <= p4)
                begin
                    root = cand;
                end
            end
            res.speed = root > 65535 ? 16'hFFFF : root[15:0];
        end
        res.v1x = clamp_vel(v1x);
        res.v1y = clamp_vel(v1y);
        res.v2x = clamp_vel(v2x);
        res.v2y = clamp_vel(v2y);
        return res;
    endfunction

    // Sends one request after a random gap; checks a typed-in result if given.
    task automatic send_pair(pair_t f, bit has_fixed, response_t fixed);
        response_t pred;
        int        gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pred = collide(f);
        if (has_fixed && pred != fixed)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("directed row disagrees with prediction: %h vs %h", fixed, pred);
            end
        end
        expected_responses.insert(expected_responses.size(), has_fixed ? fixed : pred);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_pair(f);
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_vel();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_mass();
        case ($urandom_range(0, 6))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random pair: mostly close discs so that hits are common.
    function automatic pair_t rand_pair();
        pair_t f;
        int    sep;
        int    kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++)
        begin
            f[i] = 16'($urandom);
        end
        f[5][15]  = 1'b0;
        f[11][15] = 1'b0;
        f[2]  = rand_vel();
        f[3]  = rand_vel();
        f[8]  = rand_vel();
        f[9]  = rand_vel();
        f[4]  = rand_mass();
        f[10] = rand_mass();
        if (kind < 7)
        begin
            sep   = kind < 3 ? 4 : (kind < 5 ? 400 : 30000);
            f[6]  = f[0] + 16'($signed($urandom_range(0, 2 * sep)) - sep);
            f[7]  = f[1] + 16'($signed($urandom_range(0, 2 * sep)) - sep);
            f[5]  = 16'($urandom_range(0, 2 * sep));
            f[11] = 16'($urandom_range(0, 2 * sep));
            if (kind == 6)
            begin
                f[5]  = 16'h7FFF;
                f[11] = 16'h7FFF;
            end
        end
        else if (kind == 7)
        begin
            f[6] = f[0];
            f[7] = f[1];
        end
        return f;
    endfunction

    // Stimulus: reset, directed table, then random pairs.
    initial
    begin
        pair_t     row;
        response_t r;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        mismatch_count = 0;
        stimulus_done  = 0;

        // Head-on, equal masses: normal components swap, speed 20.
        row = '{0, 0, 10, 0, 256, 10, 16, 0, -10, 0, 256, 10};
        r = '{16'hFFF6, 0, 16'd10, 0, 1'b1, 16'd20};
        add_row(row, 1, r);
        // Receding discs pass through.
        row = '{0, 0, -10, 0, 256, 10, 16, 0, 10, 0, 256, 10};
        r = '{16'hFFF6, 0, 16'd10, 0, 1'b0, 0};
        add_row(row, 1, r);
        // Coincident centres count as no hit.
        row = '{5, 5, 100, 7, 256, 300, 5, 5, -100, 3, 256, 300};
        r = '{16'd100, 16'd7, 16'hFF9C, 16'd3, 1'b0, 0};
        add_row(row, 1, r);
        // Too far apart.
        row = '{0, 0, 50, 0, 256, 1, 100, 0, -50, 0, 256, 1};
        r = '{16'd50, 0, 16'hFFCE, 0, 1'b0, 0};
        add_row(row, 1, r);
        // Both masses zero: treated as equal.
        row = '{0, 0, 0, 10, 0, 8, 0, 8, 0, -10, 0, 8};
        r = '{0, 16'hFFF6, 0, 16'd10, 1'b1, 16'd20};
        add_row(row, 1, r);
        // One massless disc, oblique and diagonal geometry.
        row = '{0, 0, 30, 20, 0, 20, 10, 10, -5, -7, 512, 20};
        add_row(row, 0, '0);
        row = '{0, 0, 30, 20, 4096, 20, -10, 12, -5, -7, 0, 20};
        add_row(row, 0, '0);
        // Saturation of velocities and speed.
        row = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF,
                16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1, 16'h7FFF};
        add_row(row, 0, '0);
        row = '{0, 0, 16'h7FFF, 0, 1, 4, 1, 0, 16'h8000, 0, 16'hFFFF, 4};
        add_row(row, 0, '0);
        row = '{16'h7FFF, 0, 16'h8000, 16'h7FFF, 16'hFFFF, 0, 16'h7FFE, 0,
                16'h7FFF, 16'h8000, 16'hFFFF, 1};
        add_row(row, 0, '0);
        row = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF,
                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF};
        add_row(row, 0, '0);
        // Exactly touching, zero radii, half-way rounding candidates.
        row = '{0, 0, 1, 0, 256, 3, 5, 0, 0, 0, 256, 2};
        add_row(row, 0, '0);
        row = '{0, 0, 1, 1, 256, 0, 1, 0, 0, 0, 256, 0};
        add_row(row, 0, '0);
        row = '{0, 0, 3, 0, 256, 2, 1, 1, 0, 0, 768, 2};
        add_row(row, 0, '0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (table_rows[i])
        begin
            send_pair(table_rows[i], table_fixed[i], table_resp[i]);
        end
        for (int n = 0; n < 1340; n++)
        begin
            send_pair(rand_pair(), 0, '0);
        end
        s_tvalid <= 1'b0;
        stimulus_done = 1;
    end

    // Result side: random stalls, checks against the oldest expectation.
    initial
    begin
        int        stall;
        response_t got;
        response_t want;
        m_tready       = 1'b0;
        response_count = 0;
        hit_count      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0)
            begin
                stall = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                @(posedge clk);
            end
            got.v1x   = m_tdata[15:0];
            got.v1y   = m_tdata[31:16];
            got.v2x   = m_tdata[47:32];
            got.v2y   = m_tdata[63:48];
            got.speed = m_tdata[79:64];
            got.hit   = m_tuser;
            response_count++;
            if (expected_responses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected response %h", got);
                end
            end
            else
            begin
                want = expected_responses.pop_front();
                if (want.hit)
                begin
                    hit_count++;
                end
                if (got != want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("response %0d: v1 %0d,%0d v2 %0d,%0d hit %0d speed %0d",
                                 response_count, $signed(got.v1x), $signed(got.v1y),
                                 $signed(got.v2x), $signed(got.v2y), got.hit, got.speed);
                        $display("  expected v1 %0d,%0d v2 %0d,%0d hit %0d speed %0d",
                                 $signed(want.v1x), $signed(want.v1y), $signed(want.v2x),
                                 $signed(want.v2y), want.hit, want.speed);
                    end
                end
            end
        end
    end

    // End of run: drain, let the pipeline settle, then report.
    initial
    begin
        wait (stimulus_done);
        while (expected_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3 * PIPE_LAT + 20) @(posedge clk);
        $display("Checked %0d disc pair responses, %0d of them collisions.",
                 response_count, hit_count);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("Timeout with %0d responses outstanding", expected_responses.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
